FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition holds on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/mtp_pkg.sv
// Package with types, codes and the hex decoder of the MAC address text parser.
package mtp_pkg;

   localparam int CHAR_W   = 8;
   localparam int NIBBLE_W = 4;
   localparam int OCTET_W  = 8;
   localparam int OCTETS   = 6;
   localparam int MAC_W    = OCTETS * OCTET_W;
   localparam int IDX_W    = 3;
   localparam int DCNT_W   = 2;
   localparam int SEP_W    = 2;
   // result item: valid_res, mac_address, padded to whole bytes
   localparam int RSP_W    = ((1 + MAC_W + 7) / 8) * 8;

   // separator kinds
   localparam logic [SEP_W-1:0] SEP_NONE  = 2'd0;
   localparam logic [SEP_W-1:0] SEP_DASH  = 2'd1;
   localparam logic [SEP_W-1:0] SEP_COLON = 2'd2;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;

   localparam logic [IDX_W-1:0]  LAST_IDX   = 3'd5;
   localparam logic [DCNT_W-1:0] MAX_DIGITS = 2'd2;

   typedef struct packed {
      logic                is_hex;
      logic [NIBBLE_W-1:0] value;
   } hex_type;

   // Decode one ASCII character as a hex digit in either case.
   function automatic hex_type hex_decode(input logic [CHAR_W-1:0] c);
      hex_type r;
      logic [CHAR_W-1:0] d;
      r = '0;
      d = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d = c - CHAR_0;
         r.is_hex = 1'b1;
         r.value  = d[NIBBLE_W-1:0];
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
         d = c - CHAR_LA + 8'd10;
         r.is_hex = 1'b1;
         r.value  = d[NIBBLE_W-1:0];
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         d = c - CHAR_UA + 8'd10;
         r.is_hex = 1'b1;
         r.value  = d[NIBBLE_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/mac_address_text_parser.sv
// Top level of the MAC address text parser: input register, parser state, result register.
//
// Parses an Ethernet address written as text, one ASCII character per item on
// the req_ channel, with req_tlast on the final character. Six groups of one or
// two hex digits, split all by '-' or all by ':', give a result item on rsp_
// with valid_res set and the address in mac_address (first octet on top); any
// other text gives valid_res clear and a zero address. Exactly one result item
// leaves for each string, when its last character has been parsed. The block
// takes one item per cycle for as long as the result side keeps up; a
// character goes through one input register and then the parse logic into the
// parser state or the result register, so the result register is loaded when
// the last character leaves the input register into a free result register,
// and rsp_tvalid is high from then on. The result register holds a result
// while rsp_tready is low, and input keeps flowing until the next last
// character meets that full register.
`include "assert_macros.svh"

module mac_address_text_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [mtp_pkg::CHAR_W-1:0] req_tdata,  // [7:0] character
   input  logic                     req_tlast,    // last_char
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [mtp_pkg::RSP_W-1:0] rsp_tdata    // [0] valid_res, [48:1] mac_address, zero pad
);
   import mtp_pkg::*;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0] s1_char_ff;
   logic              s1_last_ff;

   // parser state
   logic [MAC_W-1:0]  store_ff, store_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [SEP_W-1:0]  sep_ff, sep_in;
   logic              failed_ff, failed_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic              out_ok_ff, out_ok_in;
   logic [MAC_W-1:0]  out_mac_ff, out_mac_in;

   logic    out_free;
   logic    advance;
   logic    take;
   hex_type hx;
   logic [SEP_W-1:0] kind;
   logic [SEP_W-1:0] sel_kind;
   logic [MAC_W-1:0] store_upd;
   logic [IDX_W-1:0] idx_upd;
   logic [DCNT_W-1:0] dcnt_upd;
   logic [SEP_W-1:0] sep_upd;
   logic             failed_upd;
   logic             ok;

   // handshake
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign s1_valid_in = take || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (take) begin
         s1_char_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   // parse one character against the current state
   always_comb begin
      hx         = hex_decode(s1_char_ff);
      kind       = (s1_char_ff == CHAR_DASH)  ? SEP_DASH :
                   (s1_char_ff == CHAR_COLON) ? SEP_COLON : SEP_NONE;
      sel_kind   = (sep_ff == SEP_NONE) ? kind : sep_ff;
      store_upd  = store_ff;
      idx_upd    = idx_ff;
      dcnt_upd   = dcnt_ff;
      sep_upd    = sep_ff;
      failed_upd = failed_ff;
      if (!failed_ff) begin
         if (hx.is_hex) begin
            if (dcnt_ff >= MAX_DIGITS || idx_ff > LAST_IDX) begin
               failed_upd = 1'b1;
            end else begin
               // write the nibble into the octet of the current group
               for (int i = 0; i < OCTETS; i++) begin
                  if (idx_ff == IDX_W'(OCTETS - 1 - i)) begin
                     store_upd[i*OCTET_W +: OCTET_W] = (dcnt_ff != '0) ?
                        {store_ff[i*OCTET_W +: NIBBLE_W], hx.value} :
                        {{(OCTET_W-NIBBLE_W){1'b0}}, hx.value};
                  end
               end
               dcnt_upd = dcnt_ff + 2'd1;
            end
         end else if (kind == SEP_NONE) begin
            failed_upd = 1'b1;
         end else begin
            sep_upd = sel_kind;
            if (kind == sel_kind && dcnt_ff != '0 && idx_ff < LAST_IDX) begin
               dcnt_upd = '0;
               idx_upd  = idx_ff + 3'd1;
            end else begin
               failed_upd = 1'b1;
            end
         end
      end
      ok = !failed_upd && dcnt_upd != '0 && idx_upd == LAST_IDX;
   end

   // state and result next values
   always_comb begin
      store_in     = store_ff;
      idx_in       = idx_ff;
      dcnt_in      = dcnt_ff;
      sep_in       = sep_ff;
      failed_in    = failed_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_ok_in    = out_ok_ff;
      out_mac_in   = out_mac_ff;
      if (advance) begin
         if (s1_last_ff) begin
            store_in     = '0;
            idx_in       = '0;
            dcnt_in      = '0;
            sep_in       = SEP_NONE;
            failed_in    = 1'b0;
            out_valid_in = 1'b1;
            out_ok_in    = ok;
            out_mac_in   = ok ? store_upd : '0;
         end else begin
            store_in  = store_upd;
            idx_in    = idx_upd;
            dcnt_in   = dcnt_upd;
            sep_in    = sep_upd;
            failed_in = failed_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff     <= '0;
         idx_ff       <= '0;
         dcnt_ff      <= '0;
         sep_ff       <= SEP_NONE;
         failed_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         store_ff     <= store_in;
         idx_ff       <= idx_in;
         dcnt_ff      <= dcnt_in;
         sep_ff       <= sep_in;
         failed_ff    <= failed_in;
         out_valid_ff <= out_valid_in;
      end
      out_ok_ff  <= out_ok_in;
      out_mac_ff <= out_mac_in;
   end

   // outputs
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_W-1-MAC_W){1'b0}}, out_mac_ff, out_ok_ff};

   // checks
   `ASSERT_ALWAYS(a_idx_range, clock, reset, idx_ff <= LAST_IDX)
   `ASSERT_ALWAYS(a_dcnt_range, clock, reset, dcnt_ff <= MAX_DIGITS)
   `ASSERT_ALWAYS(a_sep_code, clock, reset, sep_ff <= SEP_COLON)
   `ASSERT_IMPLIES(a_bad_is_zero, clock, reset, out_valid_ff && !out_ok_ff, out_mac_ff == '0)
   `ASSERT_NEXT(a_fail_sticky, clock, reset, failed_ff && !(advance && s1_last_ff), failed_ff)
endmodule
